### sv/rpf_pkg.sv
package rpf_pkg;
	localparam int unsigned DimensionsDefault = 3;
	localparam int unsigned FieldW = 32;
	localparam int unsigned MassW = 31;
	localparam int unsigned R2W = 64;
	localparam int unsigned RootW = 32;
	localparam int unsigned SmagW = 64;
	localparam int unsigned KW = 64;
	localparam int unsigned NumW = 128;
	localparam int unsigned DenW = 96;
	localparam int unsigned QW = 41;
	localparam logic [QW-1:0] QCap = {1'b1, {(QW-1){1'b0}}};
	localparam logic [1:0] RegMass = 2'd0;

	typedef logic signed [FieldW-1:0] fld_t;
	typedef struct packed {
		fld_t x;
		fld_t y;
		fld_t z;
	} vec_t;
	typedef struct packed {
		vec_t pos;
		vec_t gre;
		vec_t gim;
	} item_t;
	typedef struct packed {
		vec_t fre;
		vec_t fim;
		logic at_origin;
	} res_t;

	function automatic fld_t sat_sub(input fld_t g, input logic neg, input logic [QW-1:0] q);
		logic signed [QW+1:0] v;
		logic signed [QW+1:0] c;
		c = $signed({2'b00, q});
		v = neg ? ($signed({{(QW+2-FieldW){g[FieldW-1]}}, g}) + c)
			: ($signed({{(QW+2-FieldW){g[FieldW-1]}}, g}) - c);
		if (v > $signed({{(QW+2-FieldW){1'b0}}, 1'b0, {(FieldW-1){1'b1}}}))
			return {1'b0, {(FieldW-1){1'b1}}};
		else if (v < $signed({{(QW+2-FieldW){1'b1}}, 1'b1, {(FieldW-1){1'b0}}}))
			return {1'b1, {(FieldW-1){1'b0}}};
		else
			return v[FieldW-1:0];
	endfunction
endpackage

### sv/rpf_sqrt.sv
module rpf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vin,
	input  logic [63:0] r2,
	input  rpf_pkg::item_t din,
	output logic        vout,
	output logic [63:0] r2_out,
	output logic [31:0] root,
	output rpf_pkg::item_t dout
);
	import rpf_pkg::*;
	localparam int unsigned Steps = 32;
	localparam int unsigned PerSt = 4;
	localparam int unsigned NSt = Steps / PerSt;

	logic [NSt:0]      v_s;
	logic [63:0]       rem_s [NSt+1];
	logic [31:0]       res_s [NSt+1];
	logic [63:0]       n_s   [NSt+1];
	item_t             d_s   [NSt+1];

	assign v_s[0] = vin;
	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign n_s[0] = r2;
	assign d_s[0] = din;

	for (genvar st = 0; st < NSt; st++) begin : g_st
		logic [63:0] rem_c;
		logic [31:0] res_c;
		logic [65:0] t;
		logic [65:0] trial;
		always_comb begin
			rem_c = rem_s[st];
			res_c = res_s[st];
			for (int k = 0; k < PerSt; k++) begin
				t = {rem_c, n_s[st][63 - 2*(st*PerSt+k) -: 2]};
				trial = {32'd0, res_c, 2'b01};
				if (t >= trial) begin
					rem_c = t[63:0] - trial[63:0];
					res_c = {res_c[30:0], 1'b1};
				end else begin
					rem_c = t[63:0];
					res_c = {res_c[30:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[st+1] <= 1'b0;
			end else if (en) begin
				v_s[st+1] <= v_s[st];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st+1] <= rem_c;
				res_s[st+1] <= res_c;
				n_s[st+1] <= n_s[st];
				d_s[st+1] <= d_s[st];
			end
		end
	end

	assign vout = v_s[NSt];
	assign root = res_s[NSt];
	assign r2_out = n_s[NSt];
	assign dout = d_s[NSt];
endmodule

### sv/rpf_div.sv
module rpf_div (
	input  logic              clk,
	input  logic              en,
	input  logic [127:0]      num,
	input  logic [95:0]       den,
	output logic [40:0]       quo
);
	import rpf_pkg::*;
	localparam int unsigned Bits = 128;
	localparam int unsigned PerSt = 4;
	localparam int unsigned NSt = Bits / PerSt;

	logic [96:0]  rem_s [NSt+1];
	logic [40:0]  q_s   [NSt+1];
	logic [127:0] n_s   [NSt+1];
	logic [95:0]  d_s   [NSt+1];

	assign rem_s[0] = '0;
	assign q_s[0] = '0;
	assign n_s[0] = num;
	assign d_s[0] = den;

	for (genvar st = 0; st < NSt; st++) begin : g_st
		logic [96:0] rem_c;
		logic [40:0] q_c;
		logic [97:0] t;
		always_comb begin
			rem_c = rem_s[st];
			q_c = q_s[st];
			for (int k = 0; k < PerSt; k++) begin
				t = {rem_c, n_s[st][127 - (st*PerSt+k)]};
				if (t >= {2'b00, d_s[st]}) begin
					rem_c = t[96:0] - {1'b0, d_s[st]};
					q_c = (q_c >= QCap) ? QCap
						: (({q_c[39:0], 1'b1} > QCap || q_c[40]) ? QCap : {q_c[39:0], 1'b1});
				end else begin
					rem_c = t[96:0];
					q_c = (q_c >= QCap) ? QCap
						: ({q_c[39:0], 1'b0} > QCap ? QCap : {q_c[39:0], 1'b0});
				end
				if (q_c[40] == 1'b0 && q_c[39] && 1'b0) q_c = QCap;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[st+1] <= rem_c;
				q_s[st+1] <= q_c;
				n_s[st+1] <= n_s[st];
				d_s[st+1] <= d_s[st];
			end
		end
	end

	assign quo = q_s[NSt];
endmodule

### sv/radial_projected_flux.sv
// Flat-space radial flux: one item in and one result out per cycle. Registered
// steps from input to output register: products, then the sums r^2 and s, a
// 4-bit-per-stage square root, the denominator, 2*mass*|x| and the 32x32 partial
// products of the correction numerators and their sums, six parallel restoring
// dividers of 4 bits per stage, then the saturating subtract into the output
// register. Backpressure stalls the whole pipeline.
module radial_projected_flux #(
	parameter int unsigned DIMENSIONS = rpf_pkg::DimensionsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [0:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, grad_re_x..z, grad_im_x..z
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// flux_re_x..z, flux_im_x..z
	output logic [191:0] m_tdata,
	// at_origin
	output logic         m_tuser
);
	import rpf_pkg::*;

	logic [MassW-1:0] mass_q;
	logic en;
	item_t din;
	fld_t xi [3];
	fld_t gr [3];
	fld_t gi [3];

	assign pready = 1'b1;
	assign prdata = {1'b0, mass_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= '0;
		end else if (psel && penable && pwrite && {1'b0, paddr} == RegMass) begin
			mass_q <= pwdata[MassW-1:0];
		end
	end

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			xi[d] = (d < DIMENSIONS) ? s_tdata[32*d +: 32] : '0;
			gr[d] = (d < DIMENSIONS) ? s_tdata[96+32*d +: 32] : '0;
			gi[d] = (d < DIMENSIONS) ? s_tdata[192+32*d +: 32] : '0;
		end
		din.pos = {xi[0], xi[1], xi[2]};
		din.gre = {gr[0], gr[1], gr[2]};
		din.gim = {gi[0], gi[1], gi[2]};
	end

	// stage 1: products
	logic v_s1;
	item_t d_s1;
	logic [63:0] sq_s1 [3];
	logic signed [63:0] pr_s1 [3];
	logic signed [63:0] pi_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= din;
			for (int d = 0; d < 3; d++) begin
				sq_s1[d] <= 64'(xi[d] * xi[d]);
				pr_s1[d] <= xi[d] * gr[d];
				pi_s1[d] <= xi[d] * gi[d];
			end
		end
	end

	// stage 2: sums
	logic v_s2;
	item_t d_s2;
	logic [63:0] r2_s2;
	logic signed [65:0] sr_s2, si_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d_s1;
			r2_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			sr_s2 <= 66'(pr_s1[0]) + 66'(pr_s1[1]) + 66'(pr_s1[2]);
			si_s2 <= 66'(pi_s1[0]) + 66'(pi_s1[1]) + 66'(pi_s1[2]);
		end
	end

	// side shift of s alongside the root
	localparam int unsigned SqLat = 8;
	logic signed [65:0] sr_d [SqLat+1];
	logic signed [65:0] si_d [SqLat+1];
	assign sr_d[0] = sr_s2;
	assign si_d[0] = si_s2;
	for (genvar i = 0; i < SqLat; i++) begin : g_sd
		always_ff @(posedge clk) begin
			if (en) begin
				sr_d[i+1] <= sr_d[i];
				si_d[i+1] <= si_d[i];
			end
		end
	end

	logic v_sq;
	logic [63:0] r2_sq;
	logic [31:0] r_sq;
	item_t d_sq;
	rpf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s2), .r2(r2_s2), .din(d_s2),
		.vout(v_sq), .r2_out(r2_sq), .root(r_sq), .dout(d_sq)
	);

	// stage 3: den partial products, magnitudes, k = 2*mass*|x|
	logic v_s3;
	item_t d_s3;
	logic [63:0] dl_s3, dh_s3;
	logic z_s3;
	logic [63:0] smr_s3, smi_s3;
	logic snr_s3, sni_s3;
	logic [63:0] k_s3 [3];
	fld_t xa [3];
	always_comb begin
		xa[0] = d_sq.pos.x;
		xa[1] = d_sq.pos.y;
		xa[2] = d_sq.pos.z;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_sq;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= d_sq;
			dl_s3 <= r2_sq[31:0] * r_sq;
			dh_s3 <= r2_sq[63:32] * r_sq;
			z_s3 <= (r2_sq == '0);
			snr_s3 <= sr_d[SqLat][65];
			sni_s3 <= si_d[SqLat][65];
			smr_s3 <= sr_d[SqLat][65] ? 64'(-sr_d[SqLat]) : sr_d[SqLat][63:0];
			smi_s3 <= si_d[SqLat][65] ? 64'(-si_d[SqLat]) : si_d[SqLat][63:0];
			for (int d = 0; d < 3; d++)
				k_s3[d] <= {mass_q, 1'b0} * (xa[d][31] ? 32'(-xa[d]) : 32'(xa[d]));
		end
	end

	// stage 4: den sum, numerator partial products
	logic v_s4;
	item_t d_s4;
	logic [95:0] den_s4;
	logic z_s4;
	logic snr_s4, sni_s4;
	logic [63:0] pnr_s4 [3][4];
	logic [63:0] pni_s4 [3][4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= d_s3;
			den_s4 <= {dh_s3, 32'd0} + {32'd0, dl_s3};
			z_s4 <= z_s3;
			snr_s4 <= snr_s3;
			sni_s4 <= sni_s3;
			for (int d = 0; d < 3; d++) begin
				pnr_s4[d][0] <= k_s3[d][31:0] * smr_s3[31:0];
				pnr_s4[d][1] <= k_s3[d][31:0] * smr_s3[63:32];
				pnr_s4[d][2] <= k_s3[d][63:32] * smr_s3[31:0];
				pnr_s4[d][3] <= k_s3[d][63:32] * smr_s3[63:32];
				pni_s4[d][0] <= k_s3[d][31:0] * smi_s3[31:0];
				pni_s4[d][1] <= k_s3[d][31:0] * smi_s3[63:32];
				pni_s4[d][2] <= k_s3[d][63:32] * smi_s3[31:0];
				pni_s4[d][3] <= k_s3[d][63:32] * smi_s3[63:32];
			end
		end
	end

	// stage 5: numerators
	logic v_s5;
	item_t d_s5;
	logic [95:0] den_s5;
	logic z_s5;
	logic snr_s5, sni_s5;
	logic [127:0] nr_s5 [3];
	logic [127:0] ni_s5 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s5 <= d_s4;
			den_s5 <= den_s4;
			z_s5 <= z_s4;
			snr_s5 <= snr_s4;
			sni_s5 <= sni_s4;
			for (int d = 0; d < 3; d++) begin
				nr_s5[d] <= {64'd0, pnr_s4[d][0]} + {32'd0, pnr_s4[d][1], 32'd0}
					+ {32'd0, pnr_s4[d][2], 32'd0} + {pnr_s4[d][3], 64'd0};
				ni_s5[d] <= {64'd0, pni_s4[d][0]} + {32'd0, pni_s4[d][1], 32'd0}
					+ {32'd0, pni_s4[d][2], 32'd0} + {pni_s4[d][3], 64'd0};
			end
		end
	end

	localparam int unsigned DvLat = 32;
	logic [DvLat:0] v_dv;
	item_t d_dv [DvLat+1];
	logic [DvLat:0] z_dv, snr_dv, sni_dv;
	assign v_dv[0] = v_s5;
	assign d_dv[0] = d_s5;
	assign z_dv[0] = z_s5;
	assign snr_dv[0] = snr_s5;
	assign sni_dv[0] = sni_s5;
	for (genvar i = 0; i < DvLat; i++) begin : g_dd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv[i+1] <= 1'b0;
			else if (en) v_dv[i+1] <= v_dv[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_dv[i+1] <= d_dv[i];
				z_dv[i+1] <= z_dv[i];
				snr_dv[i+1] <= snr_dv[i];
				sni_dv[i+1] <= sni_dv[i];
			end
		end
	end

	logic [QW-1:0] qr [3];
	logic [QW-1:0] qi [3];
	logic [95:0] den_safe;
	assign den_safe = z_s5 ? 96'd1 : den_s5;
	for (genvar d = 0; d < 3; d++) begin : g_dv
		rpf_div u_dr (.clk(clk), .en(en), .num(nr_s5[d]), .den(den_safe), .quo(qr[d]));
		rpf_div u_di (.clk(clk), .en(en), .num(ni_s5[d]), .den(den_safe), .quo(qi[d]));
	end

	// output stage
	item_t df;
	fld_t fx [3];
	fld_t fgr [3];
	fld_t fgi [3];
	res_t res;
	always_comb begin
		df = d_dv[DvLat];
		fx[0] = df.pos.x; fx[1] = df.pos.y; fx[2] = df.pos.z;
		fgr[0] = df.gre.x; fgr[1] = df.gre.y; fgr[2] = df.gre.z;
		fgi[0] = df.gim.x; fgi[1] = df.gim.y; fgi[2] = df.gim.z;
		for (int d = 0; d < 3; d++) begin
			if (z_dv[DvLat]) begin
				fgr[d] = fgr[d];
				fgi[d] = fgi[d];
			end else begin
				fgr[d] = sat_sub(fgr[d], fx[d][31] ^ snr_dv[DvLat], qr[d]);
				fgi[d] = sat_sub(fgi[d], fx[d][31] ^ sni_dv[DvLat], qi[d]);
			end
		end
		res.fre = {fgr[0], fgr[1], fgr[2]};
		res.fim = {fgi[0], fgi[1], fgi[2]};
		res.at_origin = z_dv[DvLat];
	end

	logic v_q;
	res_t res_q;
	assign en = !v_q || m_tready;
	assign s_tready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (en) v_q <= v_dv[DvLat];
	end
	always_ff @(posedge clk) begin
		if (en) res_q <= res;
	end

	assign m_tvalid = v_q;
	assign m_tdata = {res_q.fim.z, res_q.fim.y, res_q.fim.x,
		res_q.fre.z, res_q.fre.y, res_q.fre.x};
	assign m_tuser = res_q.at_origin;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tuser))
		else $error("origin flag changed under stall");
`endif
endmodule
